// ----- rtl/motd_pkg.sv -----
`default_nettype none

package motd_pkg;

    // Fixed field widths
    localparam int TIME_W    = 32;
    localparam int PERIOD_W  = 24;
    localparam int SLOT_W    = 4;
    localparam int TIDX_W    = 2;
    localparam int CFG_IDX_W = 8;

    // Number of period registers on the configuration port
    localparam int REG_COUNT = 4;

    // Reset periods in microseconds
    localparam logic [PERIOD_W-1:0] PERIOD_RST_0 = 24'd40000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST_1 = 24'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST_2 = 24'd8000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST_3 = 24'd8000;

    // Scan token handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] now;
    } t_scan;

    // Write-back of the start time to the chosen cell
    typedef struct packed {
        logic              en;
        logic [TIME_W-1:0] now;
    } t_wb;

    function automatic logic [PERIOD_W-1:0] period_reset(input int idx);
        logic [PERIOD_W-1:0] val;
        unique case (idx)
            0:       val = PERIOD_RST_0;
            1:       val = PERIOD_RST_1;
            2:       val = PERIOD_RST_2;
            3:       val = PERIOD_RST_3;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/motd_cell.sv -----
`default_nettype none

module motd_cell import motd_pkg::*; #(
    parameter int IDX   = 0,
    parameter int IDX_W = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PERIOD_W-1:0]  i_cfg_data,
    input  wire t_scan                i_scan,
    input  wire logic [IDX_W-1:0]     i_pick,
    output t_scan                     o_scan,
    output logic [IDX_W-1:0]          o_pick,
    input  wire t_wb                  i_wb,
    input  wire logic [IDX_W-1:0]     i_wb_pick
);

    localparam bit HAS_REG = (IDX < REG_COUNT);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_last_start;
    t_scan               r_scan;
    logic [IDX_W-1:0]    r_pick;

    logic [TIME_W-1:0]   diff;
    logic                take;

    // Time left until due; negative means overdue
    assign diff = r_last_start + {{(TIME_W-PERIOD_W){1'b0}}, r_period} - i_scan.now;
    assign take = diff[TIME_W-1] && ($signed(diff) < $signed(i_scan.best));

    // Hold this task's period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= period_reset(IDX);
        end else if (HAS_REG && i_cfg_en && i_cfg_index == CFG_IDX_W'(IDX)) begin
            r_period <= i_cfg_data;
        end
    end

    // Record the start time when this task is dispatched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_start <= '0;
        end else if (i_wb.en && i_wb_pick == MY_IDX) begin
            r_last_start <= i_wb.now;
        end
    end

    // Advance the scan token, replacing the record when this task is later
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= i_scan.valid;
        end
        r_scan.now <= i_scan.now;
        if (take) begin
            r_scan.found <= 1'b1;
            r_scan.best  <= diff;
            r_pick       <= MY_IDX;
        end else begin
            r_scan.found <= i_scan.found;
            r_scan.best  <= i_scan.best;
            r_pick       <= i_pick;
        end
    end

    assign o_scan = r_scan;
    assign o_pick = r_pick;

endmodule

`default_nettype wire

// ----- rtl/most_overdue_task_dispatcher_unit.sv -----
`default_nettype none

// Most-overdue task dispatcher. Each input beat carries the current microsecond
// time; the block scans TASK_COUNT task cells in a row, one cell per cycle, to
// find the task furthest past its minimum period (lowest index on a tie),
// dispatches it and stores the time as its new start, or else reports the next
// idle logging slot. The accepting edge loads the first cell and each later cell
// takes the token in turn from the one before; the finished scan leaving the row
// is latched in a pending register and then committed to the output register
// once that register is free. A new item is accepted only after the previous
// result has been committed, so the block takes no new item while one is still
// in flight, and a stalled output holds off the next one. Period registers are
// written on the configuration channel, index 0..3, and must be written only
// while the block is idle.

module most_overdue_task_dispatcher_unit import motd_pkg::*; #(
    parameter int TASK_COUNT = 4,
    parameter int IDLE_SLOTS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PERIOD_W-1:0]  i_cfg_data,
    // input stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [31:0]          i_s_axis_tdata,   // [31:0] now_us
    // result stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [39:0]               o_m_axis_tdata    // [0] dispatched, [2:1] task_index,
                                                        // [34:3] lateness_us,
                                                        // [38:35] log_slot, [39] zero
);

    localparam int IDX_W = $clog2(TASK_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(IDLE_SLOTS - 1);

    t_scan            w_scan [0:TASK_COUNT];
    logic [IDX_W-1:0] w_pick [0:TASK_COUNT];
    logic [TASK_COUNT-1:0] w_stage_v;

    logic             r_busy;
    logic             r_pend_v;
    logic             r_pend_found;
    logic [TIME_W-1:0] r_pend_best;
    logic [TIME_W-1:0] r_pend_now;
    logic [IDX_W-1:0] r_pend_pick;
    logic [SLOT_W-1:0] r_idle_slot;
    logic             r_out_v;
    logic [39:0]      r_out_data;

    logic             accept;
    logic             commit;
    t_wb              wb;
    logic [SLOT_W-1:0] n_idle_slot;
    logic [TIME_W-1:0] lateness;

    assign o_cfg_ready     = 1'b1;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_busy;
    assign commit          = r_pend_v && (!r_out_v || i_m_axis_tready);

    // Launch a scan token with an empty record
    assign w_scan[0].valid = accept;
    assign w_scan[0].found = 1'b0;
    assign w_scan[0].best  = '0;
    assign w_scan[0].now   = i_s_axis_tdata;
    assign w_pick[0]       = '0;

    assign wb.en  = commit && r_pend_found;
    assign wb.now = r_pend_now;

    // Row of task cells
    for (genvar g = 0; g < TASK_COUNT; g++) begin : g_cell
        motd_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cfg_en    (i_cfg_valid && o_cfg_ready),
            .i_cfg_index (i_cfg_index),
            .i_cfg_data  (i_cfg_data),
            .i_scan      (w_scan[g]),
            .i_pick      (w_pick[g]),
            .o_scan      (w_scan[g+1]),
            .o_pick      (w_pick[g+1]),
            .i_wb        (wb),
            .i_wb_pick   (r_pend_pick)
        );
        assign w_stage_v[g] = w_scan[g+1].valid;
    end

    // Track one item from accept to commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (commit) begin
            r_busy <= 1'b0;
        end
    end

    // Hold the finished scan until the output register is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (w_scan[TASK_COUNT].valid) begin
            r_pend_v <= 1'b1;
        end else if (commit) begin
            r_pend_v <= 1'b0;
        end
        if (w_scan[TASK_COUNT].valid) begin
            r_pend_found <= w_scan[TASK_COUNT].found;
            r_pend_best  <= w_scan[TASK_COUNT].best;
            r_pend_now   <= w_scan[TASK_COUNT].now;
            r_pend_pick  <= w_pick[TASK_COUNT];
        end
    end

    // Advance the idle logging slot
    assign n_idle_slot = (r_idle_slot == LAST_SLOT) ? '0 : r_idle_slot + 1'b1;
    assign lateness    = '0 - r_pend_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_slot <= '0;
        end else if (commit && !r_pend_found) begin
            r_idle_slot <= n_idle_slot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (commit) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
        if (commit) begin
            if (r_pend_found) begin
                r_out_data <= {1'b0, {SLOT_W{1'b0}}, lateness, TIDX_W'(r_pend_pick), 1'b1};
            end else begin
                r_out_data <= {1'b0, r_idle_slot, {TIME_W{1'b0}}, {TIDX_W{1'b0}}, 1'b0};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

    // At most one scan token travels the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_stage_v, r_pend_v}))
        else $error("more than one item in the scan row");

    // An idle beat carries no task and no lateness
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |->
            (o_m_axis_tdata[34:1] == '0))
        else $error("idle result carries task fields");

    // The idle slot stays in range
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle_slot <= LAST_SLOT)
        else $error("idle slot out of range");

    // Commit frees the block for the next item
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (!r_busy && !r_pend_v))
        else $error("block stays busy after commit");

endmodule

`default_nettype wire
